// File: hdl/rbt_pkg.sv
// Shared types and codes of the record bag table engine.
package rbt_pkg;

	localparam logic [2:0] ACT_INSERT = 3'd0;
	localparam logic [2:0] ACT_REMOVE = 3'd1;
	localparam logic [2:0] ACT_QUERY  = 3'd2;
	localparam logic [2:0] ACT_SORT   = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;
	localparam logic [2:0] ACT_READ   = 3'd5;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_INDEX = 2'd3;

	typedef struct packed {
		logic [1:0] size;
		logic [1:0] color;
	} entry_t;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic [6:0] total;
		logic [6:0] ccount;
		logic [6:0] scount;
		logic [1:0] rcolor;
		logic [1:0] rsize;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_RDW  = 3'b100
	} state_t;

endpackage

// File: hdl/rbt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module rbt_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/record_bag_table_engine_top.sv
// Record bag table engine: ordered record table in a RAM with a scan sequencer.
// Insert, clear and early-out cases finish straight from idle, read goes through the
// read-wait state, query and remove scan the filled entries once, and sort scans them
// in repeated passes, up to fill passes; one RAM read and one write per cycle.
// One item is worked on at a time; busy is high only in the scan and read-wait states.
// Reset clears the fill count and the sequencer; RAM contents stay as they are and
// only entries below the fill count are read. Results cannot be stalled.
module record_bag_table_engine_top
	import rbt_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] action,
	input  logic [1:0] ball_color,
	input  logic [1:0] ball_size,
	input  logic [5:0] entry_index,
	output logic       done,
	output logic [1:0] status,
	output logic       found,
	output logic [6:0] item_total,
	output logic [6:0] color_count,
	output logic [6:0] size_count,
	output logic [1:0] read_color,
	output logic [1:0] read_size
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int XW = (CW > 6) ? CW : 6;

	state_t        state_q, state_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic          vld_s1, vld_d;
	logic [AW-1:0] pos_s1, pos_d;
	logic [2:0]    op_q, op_d;
	entry_t        rec_q, rec_d, rec_in;
	logic          found_q, found_d;
	logic [CW-1:0] ccnt_q, ccnt_d, scnt_q, scnt_d;
	entry_t        carry_q, carry_d;
	logic          swap_q, swap_d;
	logic          done_q, res_ld;
	res_t          res_q, res_d;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, ram_rdata;

	logic [CW-1:0] fill_m1;
	logic [CW-1:0] fill_p1;
	logic [AW-1:0] pos_m1;

	assign rec_in  = '{size: ball_size, color: ball_color};
	assign fill_m1 = fill_q - CW'(1);
	assign fill_p1 = fill_q + CW'(1);
	assign pos_m1  = pos_s1 - AW'(1);

	rbt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		ptr_d     = ptr_q;
		vld_d     = 1'b0;
		pos_d     = pos_s1;
		op_d      = op_q;
		rec_d     = rec_q;
		found_d   = found_q;
		ccnt_d    = ccnt_q;
		scnt_d    = scnt_q;
		carry_d   = carry_q;
		swap_d    = swap_q;
		ram_we    = 1'b0;
		ram_waddr = fill_q[AW-1:0];
		ram_wdata = rec_in;
		ram_re    = 1'b0;
		ram_raddr = ptr_q[AW-1:0];
		res_ld    = 1'b0;
		res_d     = '0;
		res_d.total = 7'(fill_q);

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_d    = action;
					rec_d   = rec_in;
					found_d = 1'b0;
					ccnt_d  = '0;
					scnt_d  = '0;
					swap_d  = 1'b0;
					ptr_d   = '0;
					case (action)
						ACT_INSERT: begin
							res_ld = 1'b1;
							if (fill_q == CW'(TABLE_DEPTH)) begin
								res_d.status = STAT_FULL;
							end else begin
								ram_we      = 1'b1;
								fill_d      = fill_p1;
								res_d.total = 7'(fill_p1);
							end
						end
						ACT_REMOVE: begin
							if (fill_q == '0) begin
								res_ld       = 1'b1;
								res_d.status = STAT_EMPTY;
							end else begin
								state_d = ST_SCAN;
							end
						end
						ACT_QUERY: begin
							if (fill_q == '0) begin
								res_ld = 1'b1;
							end else begin
								state_d = ST_SCAN;
							end
						end
						ACT_SORT: begin
							if (fill_q <= CW'(1)) begin
								res_ld = 1'b1;
							end else begin
								state_d = ST_SCAN;
							end
						end
						ACT_CLEAR: begin
							fill_d      = '0;
							res_ld      = 1'b1;
							res_d.total = 7'd0;
						end
						ACT_READ: begin
							if (XW'(entry_index) >= XW'(fill_q)) begin
								res_ld       = 1'b1;
								res_d.status = STAT_INDEX;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = AW'(entry_index);
								state_d   = ST_RDW;
							end
						end
						default: begin
							res_ld = 1'b1;
						end
					endcase
				end
			end

			ST_RDW: begin
				res_ld       = 1'b1;
				res_d.rcolor = ram_rdata.color;
				res_d.rsize  = ram_rdata.size;
				state_d      = ST_IDLE;
			end

			ST_SCAN: begin
				// Reads run two entries ahead of the write-back, so a write at
				// position p-1 never meets the read of position p+1.
				if (ptr_q != fill_q) begin
					ram_re = 1'b1;
					ptr_d  = ptr_q + CW'(1);
					vld_d  = 1'b1;
					pos_d  = ptr_q[AW-1:0];
				end

				if (vld_s1) begin
					case (op_q)
						ACT_REMOVE: begin
							if (found_q) begin
								ram_we    = 1'b1;
								ram_waddr = pos_m1;
								ram_wdata = ram_rdata;
							end else if (ram_rdata == rec_q) begin
								found_d = 1'b1;
							end
						end
						ACT_QUERY: begin
							if (ram_rdata == rec_q) begin
								found_d = 1'b1;
							end
							if (ram_rdata.color == rec_q.color) begin
								ccnt_d = ccnt_q + CW'(1);
							end
							if (ram_rdata.size == rec_q.size) begin
								scnt_d = scnt_q + CW'(1);
							end
						end
						ACT_SORT: begin
							// The carry holds the entry with the largest size seen so far in this pass.
							if (pos_s1 == '0) begin
								carry_d = ram_rdata;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = pos_m1;
								if (carry_q.size > ram_rdata.size) begin
									ram_wdata = ram_rdata;
									swap_d    = 1'b1;
								end else begin
									ram_wdata = carry_q;
									carry_d   = ram_rdata;
								end
							end
						end
						default: begin
						end
					endcase
				end else if (ptr_q == fill_q) begin
					case (op_q)
						ACT_SORT: begin
							ram_we    = 1'b1;
							ram_waddr = fill_m1[AW-1:0];
							ram_wdata = carry_q;
							if (swap_q) begin
								swap_d = 1'b0;
								ptr_d  = '0;
							end else begin
								res_ld  = 1'b1;
								state_d = ST_IDLE;
							end
						end
						ACT_REMOVE: begin
							res_ld      = 1'b1;
							res_d.found = found_q;
							if (found_q) begin
								fill_d      = fill_m1;
								res_d.total = 7'(fill_m1);
							end
							state_d = ST_IDLE;
						end
						default: begin
							res_ld       = 1'b1;
							res_d.found  = found_q;
							res_d.ccount = 7'(ccnt_q);
							res_d.scount = 7'(scnt_q);
							state_d      = ST_IDLE;
						end
					endcase
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			ptr_q   <= ptr_d;
			vld_s1  <= vld_d;
			done_q  <= res_ld;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1  <= pos_d;
		op_q    <= op_d;
		rec_q   <= rec_d;
		found_q <= found_d;
		ccnt_q  <= ccnt_d;
		scnt_q  <= scnt_d;
		carry_q <= carry_d;
		swap_q  <= swap_d;
		if (res_ld) begin
			res_q <= res_d;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign status      = res_q.status;
	assign found       = res_q.found;
	assign item_total  = res_q.total;
	assign color_count = res_q.ccount;
	assign size_count  = res_q.scount;
	assign read_color  = res_q.rcolor;
	assign read_size   = res_q.rsize;

endmodule

// File: hdl/rbt_checker.sv
// Port-level checks of the record bag table engine and their bind to the top level.
module rbt_checker
	import rbt_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [2:0] action,
	input logic       done,
	input logic [1:0] status,
	input logic       found,
	input logic [6:0] item_total
);

	// An insert beat always completes on the next cycle.
	a_insert_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action == ACT_INSERT |=> done)
		else $error("insert did not complete in one cycle");

	// A clear beat completes at once and leaves the table empty.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action == ACT_CLEAR |=> done && item_total == 7'd0)
		else $error("clear did not report an empty table");

	// A match is only ever reported with an ok status.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == STAT_OK)
		else $error("match reported with an error status");

	// A full refusal reports the table at its capacity.
	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_FULL |-> item_total == 7'(TABLE_DEPTH))
		else $error("full status with a total below capacity");

endmodule

bind record_bag_table_engine_top rbt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_rbt_checker (.*);
